// ===== hw/rtl/gql_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_pkg
// Types and constants shared by the glyph quad layout block.
// ----------------------------------------------------------------------------
package gql_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CHAR  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_QUAD    = 2'd0,
    STAT_LOADED  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CLEARED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_ATLAS_W      = 3'd0,
    REG_ATLAS_H      = 3'd1,
    REG_PIXEL_SIZE   = 3'd2,
    REG_LINE_SPACING = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5,
    REG_TEXT_RGBA    = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SCALE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_NL_MUL,
    S_NL_ADD,
    S_EMIT
  } state_e;

  localparam logic [7:0] NewlineByte = 8'd10;
  localparam int         DivNumW     = 28;   // 16-bit atlas bound times 4096
  localparam int         DivDenW     = 13;

  typedef struct packed {
    logic        [20:0] code;
    logic        [15:0] advance;
    logic signed [15:0] plane_l;
    logic signed [15:0] plane_b;
    logic signed [15:0] plane_r;
    logic signed [15:0] plane_t;
    logic        [15:0] atlas_l;
    logic        [15:0] atlas_b;
    logic        [15:0] atlas_r;
    logic        [15:0] atlas_t;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [23:0] quad_x0;
    logic signed [23:0] quad_y0;
    logic signed [23:0] quad_x1;
    logic signed [23:0] quad_y1;
    logic        [15:0] tex_u0;
    logic        [15:0] tex_v0;
    logic        [15:0] tex_u1;
    logic        [15:0] tex_v1;
    logic        [31:0] quad_rgba;
  } res_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gql_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_req_if / gql_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface gql_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  req_type;
  logic        [20:0] code;
  logic               first_char;
  logic        [15:0] advance_em;
  logic signed [15:0] plane_l;
  logic signed [15:0] plane_b;
  logic signed [15:0] plane_r;
  logic signed [15:0] plane_t;
  logic        [15:0] atlas_l;
  logic        [15:0] atlas_b;
  logic        [15:0] atlas_r;
  logic        [15:0] atlas_t;

  modport source (output valid, req_type, code, first_char, advance_em, plane_l, plane_b,
                  plane_r, plane_t, atlas_l, atlas_b, atlas_r, atlas_t, input ready);
  modport sink   (input valid, req_type, code, first_char, advance_em, plane_l, plane_b,
                  plane_r, plane_t, atlas_l, atlas_b, atlas_r, atlas_t, output ready);
endinterface

interface gql_res_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [23:0] quad_x0;
  logic signed [23:0] quad_y0;
  logic signed [23:0] quad_x1;
  logic signed [23:0] quad_y1;
  logic        [15:0] tex_u0;
  logic        [15:0] tex_v0;
  logic        [15:0] tex_u1;
  logic        [15:0] tex_v1;
  logic        [31:0] quad_rgba;

  modport source (output valid, status, quad_x0, quad_y0, quad_x1, quad_y1, tex_u0, tex_v0,
                  tex_u1, tex_v1, quad_rgba, input ready);
  modport sink   (input valid, status, quad_x0, quad_y0, quad_x1, quad_y1, tex_u0, tex_v0,
                  tex_u1, tex_v1, quad_rgba, output ready);
endinterface

// ===== hw/rtl/gql_glyph_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_glyph_mem
// Glyph table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gql_glyph_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  gql_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AddrW-1:0] raddr_i,
  output gql_pkg::entry_t rdata_o
);

  gql_pkg::entry_t mem_q [Depth];
  gql_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gql_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gql_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gql_pkg::div_req_t            req_i,
  output logic                         done_o,
  output logic [gql_pkg::DivNumW-1:0]  quot_o
);

  localparam int CntW = $clog2(gql_pkg::DivNumW + 1);

  logic [gql_pkg::DivNumW-1:0] quot_q;
  logic [gql_pkg::DivDenW-1:0] rem_q, den_q;
  logic [CntW-1:0]             cnt_q;
  logic                        busy_q, done_q;
  logic [gql_pkg::DivDenW:0]   shifted;
  logic                        ge;

  assign shifted = {rem_q, quot_q[gql_pkg::DivNumW-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(gql_pkg::DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // A zero divisor yields an all-ones quotient, which saturates downstream.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      rem_q  <= ge ? gql_pkg::DivDenW'(shifted - {1'b0, den_q})
                   : shifted[gql_pkg::DivDenW-1:0];
      quot_q <= {quot_q[gql_pkg::DivNumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/glyph_quad_layout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Glyph table plus pen state; turns character items into textured quads.
// ----------------------------------------------------------------------------
// Usage:
// Request items arrive on req_i, result items leave on res_o, both valid/ready.
// A load item appends an entry to the glyph table (or reports it full), a clear
// item empties it; each gives one result through the emit state.
// A character item is looked up by walking the table memory entry by entry,
// each entry read and then compared. A hit then goes through the scaling steps
// on the shared multiplier and four divisions on the shared divider for the
// texture coordinates. A miss returns to idle with no result, as does a newline.
// One item is worked on at a time. The result sits in an output register, so
// a new item is accepted while the previous result is still waiting; if the
// receiver stalls, the next result holds the block until the register frees.
// Reset empties the table (fill count to zero), zeroes the pen and loads the
// configuration defaults; no clearing pass is needed.
// Configuration must be written over the APB port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module glyph_quad_layout #(
  parameter int MAX_GLYPHS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gql_req_if.sink     req_i,
  gql_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CntW = $clog2(MAX_GLYPHS + 1);
  localparam int IdxW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

  // Configuration registers
  logic        [12:0] atlas_w_q, atlas_h_q;
  logic        [15:0] pixel_size_q, line_spacing_q;
  logic signed [23:0] origin_x_q, origin_y_q;
  logic        [31:0] text_rgba_q;

  gql_pkg::state_e state_q, state_d;

  logic [CntW-1:0]    cnt_q;
  logic [IdxW-1:0]    idx_q;
  logic [2:0]         step_q;
  logic [1:0]         dk_q;
  logic signed [23:0] pen_x_q, pen_y_q;
  logic               res_vld_q;
  gql_pkg::res_t      res_q;

  // Working payload registers
  logic [7:0]         byte_q;
  gql_pkg::status_e   stat_q;
  gql_pkg::entry_t    ent_q;
  logic signed [33:0] prod_q;
  logic signed [23:0] x0_q, y0_q, x1_q, y1_q;
  logic [15:0]        u0_q, v0_q, u1_q, v1_q;

  logic               req_acc, cfg_wr, table_full, hit, last;
  logic               mem_we, mem_re, res_load;
  gql_pkg::entry_t    wr_entry, rd_entry;
  gql_pkg::div_req_t  div_req;
  logic               div_done;
  logic [gql_pkg::DivNumW-1:0] quot;
  logic [15:0]        div_a;
  logic [12:0]        div_size;
  logic signed [16:0] em;
  logic signed [21:0] scaled;
  logic signed [25:0] sum_add, sum_sub, nl_sum;
  logic [15:0]        tex_u, tex_v;

  assign req_acc    = req_i.valid && req_i.ready;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign table_full = cnt_q >= CntW'(MAX_GLYPHS);
  assign hit        = rd_entry.code == 21'(byte_q);
  assign last       = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  // ---------------------------------------------------------------- APB
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q      <= 13'd512;
      atlas_h_q      <= 13'd512;
      pixel_size_q   <= 16'd8192;
      line_spacing_q <= 16'd4915;
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      text_rgba_q    <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      case (gql_pkg::reg_idx_e'(paddr[4:2]))
        gql_pkg::REG_ATLAS_W:      atlas_w_q      <= pwdata[12:0];
        gql_pkg::REG_ATLAS_H:      atlas_h_q      <= pwdata[12:0];
        gql_pkg::REG_PIXEL_SIZE:   pixel_size_q   <= pwdata[15:0];
        gql_pkg::REG_LINE_SPACING: line_spacing_q <= pwdata[15:0];
        gql_pkg::REG_ORIGIN_X:     origin_x_q     <= pwdata[23:0];
        gql_pkg::REG_ORIGIN_Y:     origin_y_q     <= pwdata[23:0];
        gql_pkg::REG_TEXT_RGBA:    text_rgba_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (gql_pkg::reg_idx_e'(paddr[4:2]))
      gql_pkg::REG_ATLAS_W:      prdata = {19'd0, atlas_w_q};
      gql_pkg::REG_ATLAS_H:      prdata = {19'd0, atlas_h_q};
      gql_pkg::REG_PIXEL_SIZE:   prdata = {16'd0, pixel_size_q};
      gql_pkg::REG_LINE_SPACING: prdata = {16'd0, line_spacing_q};
      gql_pkg::REG_ORIGIN_X:     prdata = {8'd0, origin_x_q};
      gql_pkg::REG_ORIGIN_Y:     prdata = {8'd0, origin_y_q};
      gql_pkg::REG_TEXT_RGBA:    prdata = text_rgba_q;
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- table
  always_comb begin
    wr_entry         = '0;
    wr_entry.code    = req_i.code;
    wr_entry.advance = req_i.advance_em;
    wr_entry.plane_l = req_i.plane_l;
    wr_entry.plane_b = req_i.plane_b;
    wr_entry.plane_r = req_i.plane_r;
    wr_entry.plane_t = req_i.plane_t;
    wr_entry.atlas_l = req_i.atlas_l;
    wr_entry.atlas_b = req_i.atlas_b;
    wr_entry.atlas_r = req_i.atlas_r;
    wr_entry.atlas_t = req_i.atlas_t;
  end

  assign mem_we = req_acc && (gql_pkg::req_e'(req_i.req_type) == gql_pkg::REQ_LOAD)
                  && !table_full;

  gql_glyph_mem #(
    .Depth (MAX_GLYPHS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  // ---------------------------------------------------------------- divider
  always_comb begin
    case (dk_q)
      2'd0:    begin div_a = ent_q.atlas_l; div_size = atlas_w_q; end
      2'd1:    begin div_a = ent_q.atlas_t; div_size = atlas_h_q; end
      2'd2:    begin div_a = ent_q.atlas_r; div_size = atlas_w_q; end
      default: begin div_a = ent_q.atlas_b; div_size = atlas_h_q; end
    endcase
  end

  gql_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign tex_u = (quot > gql_pkg::DivNumW'(65535)) ? 16'hFFFF : quot[15:0];
  assign tex_v = (quot > gql_pkg::DivNumW'(65535)) ? 16'd0 :
                 (quot == '0) ? 16'hFFFF : 16'(17'h10000 - {1'b0, quot[15:0]});

  // ---------------------------------------------------------------- scaling
  always_comb begin
    case (step_q)
      3'd0:    em = 17'(ent_q.plane_l);
      3'd1:    em = 17'(ent_q.plane_t);
      3'd2:    em = 17'(ent_q.plane_r);
      3'd3:    em = 17'(ent_q.plane_b);
      default: em = $signed({1'b0, ent_q.advance});
    endcase
  end

  // Arithmetic shift floors the Q4.12 x Q8.8 product down to Q14.8.
  assign scaled  = prod_q[33:12];
  assign sum_add = 26'(pen_x_q) + 26'(scaled);
  assign sum_sub = 26'(pen_y_q) - 26'(scaled);
  assign nl_sum  = 26'(pen_y_q) + $signed({6'd0, prod_q[31:12]});

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      gql_pkg::S_IDLE: begin
        if (req_acc) begin
          case (gql_pkg::req_e'(req_i.req_type))
            gql_pkg::REQ_LOAD, gql_pkg::REQ_CLEAR: state_d = gql_pkg::S_EMIT;
            gql_pkg::REQ_CHAR: begin
              if (req_i.code[7:0] == gql_pkg::NewlineByte) begin
                state_d = gql_pkg::S_NL_MUL;
              end else if (cnt_q != '0) begin
                state_d = gql_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      gql_pkg::S_READ: state_d = gql_pkg::S_CMP;
      gql_pkg::S_CMP: begin
        if (hit) begin
          state_d = gql_pkg::S_SCALE;
        end else if (last) begin
          state_d = gql_pkg::S_IDLE;
        end else begin
          state_d = gql_pkg::S_READ;
        end
      end
      gql_pkg::S_SCALE: begin
        if (step_q == 3'd5) state_d = gql_pkg::S_DIV_GO;
      end
      gql_pkg::S_DIV_GO: state_d = gql_pkg::S_DIV_WAIT;
      gql_pkg::S_DIV_WAIT: begin
        if (div_done) state_d = (dk_q == 2'd3) ? gql_pkg::S_EMIT : gql_pkg::S_DIV_GO;
      end
      gql_pkg::S_NL_MUL: state_d = gql_pkg::S_NL_ADD;
      gql_pkg::S_NL_ADD: state_d = gql_pkg::S_IDLE;
      gql_pkg::S_EMIT: begin
        if (!res_vld_q || res_o.ready) state_d = gql_pkg::S_IDLE;
      end
      default: state_d = gql_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready   = 1'b0;
    mem_re        = 1'b0;
    res_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {div_a, 12'd0};
    div_req.den   = div_size;
    case (state_q)
      gql_pkg::S_IDLE:   req_i.ready   = 1'b1;
      gql_pkg::S_READ:   mem_re        = 1'b1;
      gql_pkg::S_DIV_GO: div_req.start = 1'b1;
      gql_pkg::S_EMIT:   res_load      = !res_vld_q || res_o.ready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gql_pkg::S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      step_q    <= '0;
      dk_q      <= '0;
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        gql_pkg::S_IDLE: begin
          idx_q  <= '0;
          step_q <= '0;
          dk_q   <= '0;
          if (req_acc) begin
            case (gql_pkg::req_e'(req_i.req_type))
              gql_pkg::REQ_LOAD:  if (!table_full) cnt_q <= cnt_q + CntW'(1);
              gql_pkg::REQ_CLEAR: cnt_q <= '0;
              gql_pkg::REQ_CHAR: begin
                if (req_i.first_char) begin
                  pen_x_q <= origin_x_q;
                  pen_y_q <= origin_y_q;
                end
              end
              default: ;
            endcase
          end
        end
        gql_pkg::S_CMP: begin
          if (!hit) idx_q <= idx_q + IdxW'(1);
        end
        gql_pkg::S_SCALE: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) pen_x_q <= gql_pkg::sat24(sum_add);
        end
        gql_pkg::S_DIV_WAIT: begin
          if (div_done) dk_q <= dk_q + 2'd1;
        end
        gql_pkg::S_NL_ADD: begin
          pen_x_q <= origin_x_q;
          pen_y_q <= gql_pkg::sat24(nl_sum);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      gql_pkg::S_IDLE: begin
        byte_q <= req_i.code[7:0];
        case (gql_pkg::req_e'(req_i.req_type))
          gql_pkg::REQ_LOAD:  stat_q <= table_full ? gql_pkg::STAT_FULL : gql_pkg::STAT_LOADED;
          gql_pkg::REQ_CLEAR: stat_q <= gql_pkg::STAT_CLEARED;
          default:            stat_q <= gql_pkg::STAT_QUAD;
        endcase
      end
      gql_pkg::S_CMP: begin
        if (hit) ent_q <= rd_entry;
      end
      gql_pkg::S_SCALE: begin
        prod_q <= 34'(em * $signed({1'b0, pixel_size_q}));
        case (step_q)
          3'd1:    x0_q <= gql_pkg::sat24(sum_add);
          3'd2:    y0_q <= gql_pkg::sat24(sum_sub);
          3'd3:    x1_q <= gql_pkg::sat24(sum_add);
          3'd4:    y1_q <= gql_pkg::sat24(sum_sub);
          default: ;
        endcase
      end
      gql_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          case (dk_q)
            2'd0:    u0_q <= tex_u;
            2'd1:    v0_q <= tex_v;
            2'd2:    u1_q <= tex_u;
            default: v1_q <= tex_v;
          endcase
        end
      end
      gql_pkg::S_NL_MUL: prod_q <= $signed({2'd0, 32'(line_spacing_q) * 32'(pixel_size_q)});
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q.status <= stat_q;
      if (stat_q == gql_pkg::STAT_QUAD) begin
        res_q.quad_x0   <= x0_q;
        res_q.quad_y0   <= y0_q;
        res_q.quad_x1   <= x1_q;
        res_q.quad_y1   <= y1_q;
        res_q.tex_u0    <= u0_q;
        res_q.tex_v0    <= v0_q;
        res_q.tex_u1    <= u1_q;
        res_q.tex_v1    <= v1_q;
        res_q.quad_rgba <= text_rgba_q;
      end else begin
        res_q.quad_x0   <= '0;
        res_q.quad_y0   <= '0;
        res_q.quad_x1   <= '0;
        res_q.quad_y1   <= '0;
        res_q.tex_u0    <= '0;
        res_q.tex_v0    <= '0;
        res_q.tex_u1    <= '0;
        res_q.tex_v1    <= '0;
        res_q.quad_rgba <= '0;
      end
    end
  end

  assign res_o.valid     = res_vld_q;
  assign res_o.status    = res_q.status;
  assign res_o.quad_x0   = res_q.quad_x0;
  assign res_o.quad_y0   = res_q.quad_y0;
  assign res_o.quad_x1   = res_q.quad_x1;
  assign res_o.quad_y1   = res_q.quad_y1;
  assign res_o.tex_u0    = res_q.tex_u0;
  assign res_o.tex_v0    = res_q.tex_v0;
  assign res_o.tex_u1    = res_q.tex_u1;
  assign res_o.tex_v1    = res_q.tex_v1;
  assign res_o.quad_rgba = res_q.quad_rgba;

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_GLYPHS))
    else $error("glyph count exceeds table depth");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gql_pkg::S_CMP |-> CntW'(idx_q) < cnt_q)
    else $error("lookup compares an entry beyond the fill count");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == gql_pkg::S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gql_pkg::S_EMIT && state_d == gql_pkg::S_IDLE |=> res_vld_q)
    else $error("result not presented after leaving emit");

endmodule
